// ===== design/bounded_deque_with_search_assert.svh =====
// assertion macros shared by the deque rtl
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// condition holds at every edge out of reset
`define BDQ_ASSERT_HOLD(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deque invariant violated");

// consequent holds in the same cycle as the antecedent
`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque implication violated");

// consequent holds in the cycle after the antecedent
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque next-cycle check violated");

`endif

// ===== design/bdq_pkg.sv =====
// types and constants of the bounded deque with search
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POPPED_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    // popped, found, count packed, padded to whole bytes
    localparam int M_DATA_W = ((POPPED_W + 1 + COUNT_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_SRCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [POPPED_W-1:0] popped;
        logic                found;
        status_t             status;
        logic [COUNT_W-1:0]  count;
    } res_t;

endpackage

`default_nettype wire

// ===== design/bdq_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bounded_deque_with_search.sv =====
// top level of the bounded deque with search, a ring store in one ram
// push, unused code, pop or search of an empty queue: result registered on accept
// pop of a non-empty queue: registered ram read in S_POP_RD, then delivered to the output reg
// search: one stored word compared per cycle on the read port until a match or the last word
// throughput: one item at a time; the next item is taken once its result enters the output reg
// reset: front index, count, state and output valid clear at once; ram contents stay undefined
`default_nettype none

module bounded_deque_with_search #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input item
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [bdq_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic [bdq_pkg::FUNC_W-1:0]   s_tuser,   // [2:0] func
    // result item
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    output      logic [bdq_pkg::M_DATA_W-1:0] m_tdata,   // [31:0] popped, [32] found,
                                                         // [37:33] count, rest zero
    output      logic [bdq_pkg::STATUS_W-1:0] m_tuser    // [1:0] status
);

    import bdq_pkg::*;

    `include "bounded_deque_with_search_assert.svh"

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // ring index
    localparam int OW = $clog2(DEPTH + 1);                // occupancy, holds DEPTH itself

    // ring position base + off, with off below DEPTH
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [OW-1:0] off);
        logic [OW:0] sum;
        sum = (OW + 1)'(base) + (OW + 1)'(off);
        if (sum >= (OW + 1)'(DEPTH))
        begin
            sum = sum - (OW + 1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    // control state
    state_t              state_reg, state_next;
    logic [IW-1:0]       front_reg, front_next;
    logic [OW-1:0]       occ_reg, occ_next;
    logic [OW-1:0]       srch_off_reg, srch_off_next;   // next offset to read in a search
    logic [DATA_WIDTH-1:0] srch_val_reg, srch_val_next;
    logic                m_valid_reg, m_valid_next;
    // result staging and output register
    res_t                pend_reg, pend_next;
    res_t                out_reg, out_next;

    // ram port
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // datapath helpers
    logic                  s_acc;
    logic                  out_free;
    op_t                   op;
    logic [63:0]           val_ext;
    logic [DATA_WIDTH-1:0] val_word;
    logic [63:0]           pop_ext;
    logic                  deliver;
    res_t                  res;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign op       = op_t'(s_tuser);

    // input word sign-extended from 32 bits, then kept in the store width
    assign val_ext  = 64'(signed'(s_tdata));
    assign val_word = val_ext[DATA_WIDTH-1:0];
    // stored word sign-extended into the popped field
    assign pop_ext  = 64'(signed'(ram_rdata));

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        srch_off_reg <= srch_off_next;
        srch_val_reg <= srch_val_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        occ_next      = occ_reg;
        srch_off_next = srch_off_reg;
        srch_val_next = srch_val_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = front_reg;
        ram_wdata = val_word;
        ram_re    = 1'b0;
        ram_raddr = front_reg;

        deliver    = 1'b0;
        res.popped = '0;
        res.found  = 1'b0;
        res.status = ST_OK;
        res.count  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    unique case (op)
                        OP_PUSH_FRONT:
                        begin
                            deliver = 1'b1;
                            if (occ_reg == OW'(DEPTH))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                // front steps back one slot, word lands there
                                front_next = ring_add(front_reg, OW'(DEPTH - 1));
                                ram_we     = 1'b1;
                                ram_waddr  = front_next;
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            deliver = 1'b1;
                            if (occ_reg == OW'(DEPTH))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = ring_add(front_reg, occ_reg);
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (occ_reg == '0)
                            begin
                                deliver    = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = front_reg;
                                front_next = ring_add(front_reg, OW'(1));
                                occ_next   = occ_reg - 1'b1;
                                state_next = S_POP_RD;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (occ_reg == '0)
                            begin
                                deliver    = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                occ_next   = occ_reg - 1'b1;
                                ram_re     = 1'b1;
                                ram_raddr  = ring_add(front_reg, occ_next);
                                state_next = S_POP_RD;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (occ_reg == '0)
                            begin
                                deliver = 1'b1;
                            end
                            else
                            begin
                                // first read at the front, compared next cycle
                                ram_re        = 1'b1;
                                ram_raddr     = front_reg;
                                srch_off_next = OW'(1);
                                srch_val_next = val_word;
                                state_next    = S_SRCH;
                            end
                        end
                        default:
                        begin
                            // unused operation codes leave the queue alone
                            deliver = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                deliver    = 1'b1;
                res.popped = pop_ext[POPPED_W-1:0];
            end
            S_SRCH:
            begin
                if (ram_rdata == srch_val_reg)
                begin
                    deliver   = 1'b1;
                    res.found = 1'b1;
                end
                else if (srch_off_reg == occ_reg)
                begin
                    // walked every stored word without a match
                    deliver = 1'b1;
                end
                else
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = ring_add(front_reg, srch_off_reg);
                    srch_off_next = srch_off_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                deliver = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_DONE)
        begin
            res = pend_reg;
        end
        else
        begin
            res.count = COUNT_W'(occ_next);
        end

        // hand the result to the output register, or park it while the sink stalls
        if (deliver)
        begin
            if (out_free)
            begin
                out_next     = res;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = S_DONE;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - POPPED_W - 1 - COUNT_W)'(0),
                       out_reg.count, out_reg.found, out_reg.popped};
    assign m_tuser  = out_reg.status;

    // occupancy never passes the ring size
    `BDQ_ASSERT_HOLD(a_occ_bound, clk, rst_n, occ_reg <= OW'(DEPTH))

    // a search walk only runs over a non-empty queue
    `BDQ_ASSERT_IMP(a_srch_nonempty, clk, rst_n, state_reg == S_SRCH, occ_reg != '0)

    // a pop on a non-empty queue waits for the ram read
    `BDQ_ASSERT_NEXT(a_pop_read, clk, rst_n,
        s_acc && (op == OP_POP_FRONT || op == OP_POP_BACK) && occ_reg != '0,
        state_reg == S_POP_RD)

    // a push that fits grows the queue by one
    `BDQ_ASSERT_NEXT(a_push_grow, clk, rst_n,
        s_acc && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && occ_reg != OW'(DEPTH),
        occ_reg == OW'($past(occ_reg) + 1'b1))

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the bounded deque with search
`timescale 1ns / 100ps

module tb;
    import bdq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int RANDOM_OPS   = 500;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    // watchdog limit, with a wide margin over the longest run
    localparam int LIMIT_CYCLES = 200000;

    // function codes the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    // result item layout on m_tdata, lowest bit up: popped, found, count, zero pad
    localparam int FOUND_BIT = POPPED_W;
    localparam int COUNT_LSB = POPPED_W + 1;
    localparam int PAD_LSB   = COUNT_LSB + COUNT_W;

    // results that can be read straight off the operation
    localparam res_t EMPTY_POP  = '{popped: '0, found: 1'b0, status: ST_EMPTY, count: 5'd0};
    localparam res_t QUIET_NONE = '{popped: '0, found: 1'b0, status: ST_OK, count: 5'd0};
    localparam res_t FULL_PUSH  = '{popped: '0, found: 1'b0, status: ST_FULL, count: 5'd16};

    // one row of the directed part; want is only used when typed is set
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic [4:0]         reps;
        logic               typed;
        res_t               want;
    } plan_row_t;

    localparam int PLAN_ROWS = 17;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    // shadow copy of the deque used to work out each result
    logic [VALUE_W-1:0]  shadow_words [DEPTH];
    logic [IDX_W-1:0]    shadow_front = '0;
    logic [COUNT_W-1:0]  shadow_fill  = '0;

    res_t awaited_results [$];
    int   fail_cnt   = 0;
    int   cycle_cnt  = 0;
    int   hold_cnt   = 0;
    bit   calm_send  = 1'b0;
    bit   calm_recv  = 1'b0;

    // empty queue first, then unused codes, value extremes, fill to full,
    // pushes on full, a search that hits, one that misses, and pops from both ends
    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{OP_POP_FRONT,   32'h0000_0000, 5'd1, 1'b1, EMPTY_POP},
        '{OP_POP_BACK,    32'h0000_0000, 5'd1, 1'b1, EMPTY_POP},
        '{OP_SEARCH,      32'h0000_0000, 5'd1, 1'b1, QUIET_NONE},
        '{FUNC_UNUSED_LO, 32'h0000_0000, 5'd1, 1'b1, QUIET_NONE},
        '{FUNC_UNUSED_HI, 32'hFFFF_FFFF, 5'd1, 1'b1, QUIET_NONE},
        '{OP_PUSH_BACK,   32'h7FFF_FFFF, 5'd1, 1'b1,
          '{popped: '0, found: 1'b0, status: ST_OK, count: 5'd1}},
        '{OP_PUSH_FRONT,  32'h8000_0000, 5'd1, 1'b1,
          '{popped: '0, found: 1'b0, status: ST_OK, count: 5'd2}},
        '{OP_PUSH_BACK,   32'hFFFF_FFFF, 5'd1, 1'b0, '0},
        '{OP_PUSH_FRONT,  32'h0000_0000, 5'd1, 1'b0, '0},
        '{OP_PUSH_BACK,   32'h5555_5555, 5'd6, 1'b0, '0},
        '{OP_PUSH_FRONT,  32'hAAAA_AAAA, 5'd6, 1'b0, '0},
        '{OP_PUSH_FRONT,  32'h0000_0001, 5'd1, 1'b1, FULL_PUSH},
        '{OP_PUSH_BACK,   32'h0000_0001, 5'd1, 1'b1, FULL_PUSH},
        '{OP_SEARCH,      32'h8000_0000, 5'd1, 1'b0, '0},
        '{OP_SEARCH,      32'h0000_0001, 5'd1, 1'b0, '0},
        '{OP_POP_FRONT,   32'h0000_0000, 5'd1, 1'b0, '0},
        '{OP_POP_BACK,    32'h0000_0000, 5'd1, 1'b0, '0}
    };

    bounded_deque_with_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ring position at an offset from the shadow front
    function automatic logic [IDX_W-1:0] ring_slot(input int offset);
        return IDX_W'((int'(shadow_front) + offset) % DEPTH);
    endfunction

    // apply one accepted item to the shadow deque and return its result
    function automatic res_t apply_deque_op(input logic [FUNC_W-1:0] func,
                                            input logic [VALUE_W-1:0] value);
        res_t r;
        int   i;
        r = '0;
        case (func)
            OP_PUSH_FRONT:
                if (shadow_fill == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_front = ring_slot(DEPTH - 1);
                    shadow_words[shadow_front] = value;
                    shadow_fill++;
                end
            OP_PUSH_BACK:
                if (shadow_fill == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[ring_slot(int'(shadow_fill))] = value;
                    shadow_fill++;
                end
            OP_POP_FRONT:
                if (shadow_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped = shadow_words[shadow_front];
                    shadow_front = ring_slot(1);
                    shadow_fill--;
                end
            OP_POP_BACK:
                if (shadow_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    shadow_fill--;
                    r.popped = shadow_words[ring_slot(int'(shadow_fill))];
                end
            OP_SEARCH:
                // only occupied entries are compared
                for (i = 0; i < shadow_fill; i++)
                    if (shadow_words[ring_slot(i)] == value)
                        r.found = 1'b1;
            default:
                ;   // unused codes leave the deque alone
        endcase
        r.count = shadow_fill;
        return r;
    endfunction

    // idle length: mostly none or short, now and then long, none in calm stretches
    function automatic int idle_len(input bit calm);
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        return $urandom_range(25, 8);
    endfunction

    // word to push or look for: small values so searches hit, extremes, or anything
    function automatic logic [VALUE_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return $urandom_range(7);
        if (roll < 40)
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        return $urandom;
    endfunction

    // present one item, wait for the handshake, then record what it should produce
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                             input logic typed, input res_t want);
        int   gap;
        res_t predicted;
        gap = idle_len(calm_send);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_deque_op(func, value);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // compare one delivered item with the oldest outstanding result
    task automatic check_result();
        res_t want;
        if (awaited_results.size() == 0)
        begin
            $error("result item with none outstanding: tdata %h tuser %h", m_tdata, m_tuser);
            fail_cnt++;
        end
        else
        begin
            want = awaited_results.pop_front();
            if (m_tdata[POPPED_W-1:0] !== want.popped)
            begin
                $error("popped: expected %h, got %h", want.popped, m_tdata[POPPED_W-1:0]);
                fail_cnt++;
            end
            if (m_tdata[FOUND_BIT] !== want.found)
            begin
                $error("found: expected %b, got %b", want.found, m_tdata[FOUND_BIT]);
                fail_cnt++;
            end
            if (m_tuser !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, m_tuser);
                fail_cnt++;
            end
            if (m_tdata[PAD_LSB-1:COUNT_LSB] !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count,
                       m_tdata[PAD_LSB-1:COUNT_LSB]);
                fail_cnt++;
            end
            if (m_tdata[M_DATA_W-1:PAD_LSB] !== '0)
            begin
                $error("pad: expected 0, got %h", m_tdata[M_DATA_W-1:PAD_LSB]);
                fail_cnt++;
            end
        end
    endtask

    // result side: take items and apply random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
        if ($urandom_range(99) < 2)
            calm_recv = !calm_recv;
        if (hold_cnt != 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(99) < 20)
                hold_cnt = idle_len(calm_recv);
        end
    end

    // watchdog on a hung handshake
    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        int                 roll;
        int                 counted;
        bit                 leaning_full;

        counted      = 0;
        leaning_full = 1'b1;

        // hold reset, then release it at an edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (directed_plan[row])
            repeat (directed_plan[row].reps)
                send_item(directed_plan[row].func, directed_plan[row].value,
                          directed_plan[row].typed, directed_plan[row].want);

        // random part: swing the deque between empty and full so the ring wraps
        // and both the full and the empty corner are hit many times
        while (counted < RANDOM_OPS)
        begin
            roll  = $urandom_range(99);
            value = pick_word();
            if (roll < 4)
                func = FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
            else
            begin
                counted++;
                if (roll < 20)
                begin
                    func = OP_SEARCH;
                    // mostly look for something that is stored
                    if (shadow_fill != 0 && $urandom_range(99) < 60)
                        value = shadow_words[ring_slot(int'($urandom_range(shadow_fill - 1)))];
                end
                else if (($urandom_range(99) < 75) == leaning_full)
                    func = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else
                    func = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            end
            send_item(func, value, 1'b0, '0);

            // turn around at the ends, sometimes earlier
            if (shadow_fill == DEPTH)
                leaning_full = 1'b0;
            else if (shadow_fill == 0)
                leaning_full = 1'b1;
            else if ($urandom_range(99) < 2)
                leaning_full = !leaning_full;
            if ($urandom_range(99) < 3)
                calm_send = !calm_send;
        end
        s_tvalid <= 1'b0;

        // let outstanding results drain, then watch for stray items
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/bdq_pkg.sv
design/bdq_ram.sv
design/bounded_deque_with_search.sv
verif/tb.sv
